### rtl/ymr_pkg.sv
// Package for the YMODEM packet receiver: codes, item and result types, CRC step.
// No dependencies; used by every module under rtl.
package ymr_pkg;

    localparam logic [7:0] HDR_SOH = 8'h01;
    localparam logic [7:0] HDR_STX = 8'h02;
    localparam logic [7:0] HDR_EOT = 8'h04;
    localparam logic [7:0] HDR_ACK = 8'h06;
    localparam logic [7:0] HDR_NAK = 8'h15;
    localparam logic [7:0] HDR_CAN = 8'h18;
    localparam logic [7:0] HDR_C   = 8'h43;

    localparam logic [10:0] LEN_SHORT = 11'd128;
    localparam logic [10:0] LEN_LONG  = 11'd1024;
    localparam logic [8:0]  NUM_SUM   = 9'h0ff;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] IDLE_MAX  = 16'hffff;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_PKT_OK  = 3'd1,
        KIND_CTRL_OK = 3'd2,
        KIND_TIMEOUT = 3'd3,
        KIND_CHK_ERR = 3'd4,
        KIND_UNKNOWN = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NUMBER = 3'd1,
        PH_COMPL  = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRCH   = 3'd4,
        PH_CRCL   = 3'd5
    } phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] value;
        logic [7:0] block_number;
        logic [9:0] byte_index;
    } res_t;

    // CRC-16/XMODEM, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/ymr_parser.sv
// Packet parser: phase state, packet fields, running CRC and idle tick count.
// Depends on ymr_pkg.
module ymr_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  ymr_pkg::item_t   item,
    input  logic [15:0]      timeout_ticks,
    output ymr_pkg::res_t    res
);

    ymr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  header_reg, header_next;
    logic [7:0]  number_reg, number_next;
    logic [7:0]  compl_reg, compl_next;
    logic [10:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crch_reg, crch_next;
    logic [15:0] idle_reg, idle_next;

    logic [15:0] idle_inc;
    logic [10:0] count_inc;
    logic [10:0] pkt_len;
    logic [8:0]  num_sum;
    logic [7:0]  b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ymr_pkg::PH_HEADER;
            header_reg <= '0;
            number_reg <= '0;
            compl_reg  <= '0;
            count_reg  <= '0;
            crc_reg    <= '0;
            crch_reg   <= '0;
            idle_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            number_reg <= number_next;
            compl_reg  <= compl_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            crch_reg   <= crch_next;
            idle_reg   <= idle_next;
        end
    end

    always_comb
    begin
        b         = item.rx_byte;
        idle_inc  = (idle_reg != ymr_pkg::IDLE_MAX) ? idle_reg + 16'd1 : idle_reg;
        count_inc = count_reg + 11'd1;
        pkt_len   = (header_reg == ymr_pkg::HDR_SOH) ? ymr_pkg::LEN_SHORT : ymr_pkg::LEN_LONG;
        num_sum   = {1'b0, number_reg} + {1'b0, compl_reg};

        phase_next  = phase_reg;
        header_next = header_reg;
        number_next = number_reg;
        compl_next  = compl_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        crch_next   = crch_reg;
        idle_next   = '0;

        res.valid        = 1'b0;
        res.kind         = ymr_pkg::KIND_DATA;
        res.value        = '0;
        res.block_number = '0;
        res.byte_index   = '0;

        if (item.req_type == ymr_pkg::REQ_TICK)
        begin
            idle_next = idle_inc;
            if (idle_inc >= timeout_ticks)
            begin
                idle_next  = '0;
                phase_next = ymr_pkg::PH_HEADER;
                res.valid  = 1'b1;
                res.kind   = ymr_pkg::KIND_TIMEOUT;
            end
        end
        else
        begin
            case (phase_reg)
                ymr_pkg::PH_NUMBER:
                begin
                    number_next = b;
                    phase_next  = ymr_pkg::PH_COMPL;
                end
                ymr_pkg::PH_COMPL:
                begin
                    compl_next = b;
                    count_next = '0;
                    crc_next   = '0;
                    phase_next = ymr_pkg::PH_DATA;
                end
                ymr_pkg::PH_DATA:
                begin
                    crc_next         = ymr_pkg::crc_byte(crc_reg, b);
                    count_next       = count_inc;
                    res.valid        = 1'b1;
                    res.kind         = ymr_pkg::KIND_DATA;
                    res.value        = b;
                    res.block_number = number_reg;
                    res.byte_index   = count_reg[9:0];
                    if (count_inc >= pkt_len)
                        phase_next = ymr_pkg::PH_CRCH;
                end
                ymr_pkg::PH_CRCH:
                begin
                    crch_next  = b;
                    phase_next = ymr_pkg::PH_CRCL;
                end
                ymr_pkg::PH_CRCL:
                begin
                    phase_next       = ymr_pkg::PH_HEADER;
                    res.valid        = 1'b1;
                    res.kind         = ((num_sum == ymr_pkg::NUM_SUM) &&
                                        ({crch_reg, b} == crc_reg)) ?
                                       ymr_pkg::KIND_PKT_OK : ymr_pkg::KIND_CHK_ERR;
                    res.value        = header_reg;
                    res.block_number = number_reg;
                end
                default:
                begin
                    phase_next  = ymr_pkg::PH_HEADER;
                    header_next = b;
                    res.value   = b;
                    if (b inside {ymr_pkg::HDR_SOH, ymr_pkg::HDR_STX})
                        phase_next = ymr_pkg::PH_NUMBER;
                    else if (b inside {ymr_pkg::HDR_EOT, ymr_pkg::HDR_ACK, ymr_pkg::HDR_NAK,
                                       ymr_pkg::HDR_CAN, ymr_pkg::HDR_C})
                    begin
                        res.valid = 1'b1;
                        res.kind  = ymr_pkg::KIND_CTRL_OK;
                    end
                    else
                    begin
                        res.valid = 1'b1;
                        res.kind  = ymr_pkg::KIND_UNKNOWN;
                    end
                end
            endcase
        end
    end

endmodule

### rtl/ymr_result_reg.sv
// Result register on the output channel, loaded from the parser, held under stall.
// Depends on ymr_pkg.
module ymr_result_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  ymr_pkg::res_t   res,
    input  logic            out_stall,
    output logic            can_load,
    output logic            out_valid,
    output ymr_pkg::res_t   held
);

    logic          valid_reg, valid_next;
    ymr_pkg::res_t data_reg;

    assign can_load  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign held      = data_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

endmodule

### rtl/ymodem_packet_receiver.sv
// YMODEM receive path: input register, packet parser, result register.
// Depends on ymr_pkg, ymr_parser and ymr_result_reg.
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+------------------
//  input    | req_type, rx_byte                        | in_valid/in_stall
//  output   | kind, value, block_number, byte_index    | out_valid/out_stall
//  config   | cfg_wr_data (timeout ticks)              | cfg_wr_en
//
// One item per cycle while output is not stalled; results pass the input register, then the result register.
// The parser state updates in the single cycle the item leaves the input register.
// Reset clears all parser state and sets the timeout to 100 ticks.
// Output stall holds the result register; the input register still takes one item,
// and items that give no result keep flowing while a result waits.
module ymodem_packet_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  value,
    output logic [7:0]  block_number,
    output logic [9:0]  byte_index,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic           item_valid_reg, item_valid_next;
    ymr_pkg::item_t item_reg;
    logic [15:0]    timeout_reg;
    logic           accept;
    logic           proc_fire;
    logic           can_load;
    ymr_pkg::res_t  res;
    ymr_pkg::res_t  held;

    assign proc_fire = item_valid_reg && (!res.valid || can_load);
    assign in_stall  = item_valid_reg && !proc_fire;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            item_valid_next = 1'b1;
        else if (proc_fire)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            timeout_reg    <= ymr_pkg::TIMEOUT_RESET;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.req_type <= req_type;
            item_reg.rx_byte  <= rx_byte;
        end
    end

    ymr_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (proc_fire),
        .item          (item_reg),
        .timeout_ticks (timeout_reg),
        .res           (res)
    );

    ymr_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc_fire && res.valid),
        .res       (res),
        .out_stall (out_stall),
        .can_load  (can_load),
        .out_valid (out_valid),
        .held      (held)
    );

    assign kind         = held.kind;
    assign value        = held.value;
    assign block_number = held.block_number;
    assign byte_index   = held.byte_index;

    // input backs up only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    // zero timeout: every tick times out
    a_zero_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && item_reg.req_type == ymr_pkg::REQ_TICK && timeout_reg == 16'd0)
        |=> (out_valid && kind == ymr_pkg::KIND_TIMEOUT))
        else $error("tick with zero timeout gave no timeout");

    // a new result only follows a processed item
    a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(proc_fire))
        else $error("result appeared without a processed item");

endmodule

### tb/tb.sv
// Self-checking testbench for ymodem_packet_receiver: directed table, then random packet traffic.
// Predicts untyped results from its own model of the parser and CRC; depends on ymr_pkg and ymodem_packet_receiver.
`timescale 1ns / 100ps

module tb;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int DIR_N       = 25;
    localparam int SHORT_FROM  = 15;
    localparam int PKT_ROOM    = 60;

    typedef struct packed {
        ymr_pkg::kind_t kind;
        logic [7:0]     value;
        logic [7:0]     blk;
        logic [9:0]     idx;
    } rx_result_t;

    typedef struct packed {
        logic       rq;
        logic [7:0] b;
        logic [7:0] rep;
        bit         typed;
        rx_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [7:0]  block_number;
    logic [9:0]  byte_index;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    // parser state as predicted
    ymr_pkg::phase_t cur_phase;
    logic [7:0]  hdr_code;
    logic [7:0]  pkt_num;
    logic [7:0]  pkt_compl;
    logic [10:0] data_cnt;
    logic [15:0] crc_run;
    logic [7:0]  crc_hi;
    logic [15:0] idle_cnt;
    logic [15:0] tmo_ticks;

    rx_result_t  awaited_results [$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          quiet_cycles;
    int          tick_pct = 0;
    bit          steady = 1'b0;
    bit          long_hold_req = 1'b0;

    logic [7:0]  ctrl_codes [5] = '{ymr_pkg::HDR_EOT, ymr_pkg::HDR_ACK, ymr_pkg::HDR_NAK,
                                    ymr_pkg::HDR_CAN, ymr_pkg::HDR_C};

    // typed expectation applies to the last repetition of a row;
    // rows from SHORT_FROM on run with a 4-tick timeout
    stim_row_t dir_rows [DIR_N] = '{
        '{ymr_pkg::REQ_BYTE, 8'h04, 8'd1, 1'b1, '{ymr_pkg::KIND_CTRL_OK, 8'h04, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'h06, 8'd1, 1'b1, '{ymr_pkg::KIND_CTRL_OK, 8'h06, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'h15, 8'd1, 1'b1, '{ymr_pkg::KIND_CTRL_OK, 8'h15, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'h18, 8'd1, 1'b1, '{ymr_pkg::KIND_CTRL_OK, 8'h18, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'h43, 8'd1, 1'b1, '{ymr_pkg::KIND_CTRL_OK, 8'h43, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'h00, 8'd1, 1'b1, '{ymr_pkg::KIND_UNKNOWN, 8'h00, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'hff, 8'd1, 1'b1, '{ymr_pkg::KIND_UNKNOWN, 8'hff, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_TICK, 8'haa, 8'd99, 1'b0, '0},
        '{ymr_pkg::REQ_TICK, 8'h55, 8'd1, 1'b1, '{ymr_pkg::KIND_TIMEOUT, 8'h00, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'h03, 8'd1, 1'b1, '{ymr_pkg::KIND_UNKNOWN, 8'h03, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'h01, 8'd1, 1'b0, '0},
        '{ymr_pkg::REQ_BYTE, 8'hff, 8'd1, 1'b0, '0},
        '{ymr_pkg::REQ_BYTE, 8'h00, 8'd1, 1'b0, '0},
        '{ymr_pkg::REQ_BYTE, 8'hff, 8'd1, 1'b1, '{ymr_pkg::KIND_DATA, 8'hff, 8'hff, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'h00, 8'd1, 1'b1, '{ymr_pkg::KIND_DATA, 8'h00, 8'hff, 10'd1}},
        '{ymr_pkg::REQ_TICK, 8'h00, 8'd4, 1'b1, '{ymr_pkg::KIND_TIMEOUT, 8'h00, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'h02, 8'd1, 1'b0, '0},
        '{ymr_pkg::REQ_BYTE, 8'h00, 8'd1, 1'b0, '0},
        '{ymr_pkg::REQ_BYTE, 8'h00, 8'd1, 1'b0, '0},
        '{ymr_pkg::REQ_BYTE, 8'h80, 8'd1, 1'b1, '{ymr_pkg::KIND_DATA, 8'h80, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'h01, 8'd1, 1'b0, '0},
        '{ymr_pkg::REQ_TICK, 8'hff, 8'd4, 1'b1, '{ymr_pkg::KIND_TIMEOUT, 8'h00, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'h01, 8'd1, 1'b0, '0},
        '{ymr_pkg::REQ_TICK, 8'h00, 8'd4, 1'b1, '{ymr_pkg::KIND_TIMEOUT, 8'h00, 8'h00, 10'd0}},
        '{ymr_pkg::REQ_BYTE, 8'h7f, 8'd1, 1'b1, '{ymr_pkg::KIND_UNKNOWN, 8'h7f, 8'h00, 10'd0}}
    };

    ymodem_packet_receiver u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .value        (value),
        .block_number (block_number),
        .byte_index   (byte_index),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #6 clk = ~clk;

    // CRC-16/XMODEM, bit-serial form
    function automatic logic [15:0] crc16_xmodem(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ d[k];
            c = {c[14:0], 1'b0} ^ (fb ? ymr_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_data();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 8'hff : 8'h00;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic predict_receiver_result(input logic rq, input logic [7:0] b,
                                           output bit hit, output rx_result_t r);
        logic [10:0] pkt_len;
        hit = 1'b0;
        r = '0;
        if (rq == ymr_pkg::REQ_TICK)
        begin
            if (idle_cnt != ymr_pkg::IDLE_MAX)
                idle_cnt = idle_cnt + 16'd1;
            if (idle_cnt >= tmo_ticks)
            begin
                idle_cnt = '0;
                cur_phase = ymr_pkg::PH_HEADER;
                hit = 1'b1;
                r.kind = ymr_pkg::KIND_TIMEOUT;
            end
        end
        else
        begin
            idle_cnt = '0;
            case (cur_phase)
                ymr_pkg::PH_NUMBER:
                begin
                    pkt_num = b;
                    cur_phase = ymr_pkg::PH_COMPL;
                end
                ymr_pkg::PH_COMPL:
                begin
                    pkt_compl = b;
                    data_cnt = '0;
                    crc_run = '0;
                    cur_phase = ymr_pkg::PH_DATA;
                end
                ymr_pkg::PH_DATA:
                begin
                    pkt_len = (hdr_code == ymr_pkg::HDR_SOH) ? ymr_pkg::LEN_SHORT
                                                              : ymr_pkg::LEN_LONG;
                    crc_run = crc16_xmodem(crc_run, b);
                    hit = 1'b1;
                    r.kind = ymr_pkg::KIND_DATA;
                    r.value = b;
                    r.blk = pkt_num;
                    r.idx = data_cnt[9:0];
                    data_cnt = data_cnt + 11'd1;
                    if (data_cnt >= pkt_len)
                        cur_phase = ymr_pkg::PH_CRCH;
                end
                ymr_pkg::PH_CRCH:
                begin
                    crc_hi = b;
                    cur_phase = ymr_pkg::PH_CRCL;
                end
                ymr_pkg::PH_CRCL:
                begin
                    hit = 1'b1;
                    r.kind = ({1'b0, pkt_num} + {1'b0, pkt_compl} == ymr_pkg::NUM_SUM
                              && {crc_hi, b} == crc_run) ? ymr_pkg::KIND_PKT_OK
                                                         : ymr_pkg::KIND_CHK_ERR;
                    r.value = hdr_code;
                    r.blk = pkt_num;
                    cur_phase = ymr_pkg::PH_HEADER;
                end
                default:
                begin
                    hdr_code = b;
                    cur_phase = ymr_pkg::PH_HEADER;
                    if (b == ymr_pkg::HDR_SOH || b == ymr_pkg::HDR_STX)
                        cur_phase = ymr_pkg::PH_NUMBER;
                    else
                    begin
                        hit = 1'b1;
                        r.value = b;
                        r.kind = (b == ymr_pkg::HDR_EOT || b == ymr_pkg::HDR_ACK
                                  || b == ymr_pkg::HDR_NAK || b == ymr_pkg::HDR_CAN
                                  || b == ymr_pkg::HDR_C) ? ymr_pkg::KIND_CTRL_OK
                                                          : ymr_pkg::KIND_UNKNOWN;
                    end
                end
            endcase
        end
    endtask

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t check failed: %s", $time, what);
    endtask

    task automatic push_item(input logic rq, input logic [7:0] b,
                             input bit fixed, input rx_result_t fixed_res);
        int         gap;
        bit         hit;
        rx_result_t res;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predict_receiver_result(rq, b, hit, res);
        if (fixed)
            awaited_results.push_back(fixed_res);
        else if (hit)
            awaited_results.push_back(res);
        items_sent++;
    endtask

    task automatic send(input logic rq, input logic [7:0] b);
        push_item(rq, b, 1'b0, '0);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input bit good_num, input bit good_crc);
        logic [15:0] acc;
        logic [7:0]  num;
        logic [7:0]  d;
        int          len;
        acc = '0;
        len = (hdr == ymr_pkg::HDR_SOH) ? 128 : 1024;
        num = 8'($urandom_range(0, 255));
        send(ymr_pkg::REQ_BYTE, hdr);
        send(ymr_pkg::REQ_BYTE, num);
        send(ymr_pkg::REQ_BYTE, good_num ? ~num : 8'($urandom_range(0, 255)));
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                send(ymr_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
            d = pick_data();
            acc = crc16_xmodem(acc, d);
            send(ymr_pkg::REQ_BYTE, d);
        end
        if (!good_crc)
            acc = acc ^ (16'h0001 << $urandom_range(0, 15));
        send(ymr_pkg::REQ_BYTE, acc[15:8]);
        send(ymr_pkg::REQ_BYTE, acc[7:0]);
    endtask

    // idle only: the last item may still be in flight when the queue empties
    task automatic set_timeout(input logic [15:0] v);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tmo_ticks = v;
    endtask

    // full packets only while at least PKT_ROOM items of the budget remain
    task automatic random_traffic(input int budget);
        int stop_at;
        int sel;
        int n;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45 && stop_at - items_sent >= PKT_ROOM)
                send_packet(ymr_pkg::HDR_SOH, $urandom_range(0, 9) != 0,
                            $urandom_range(0, 3) != 0);
            else if (sel < 60)
                send(ymr_pkg::REQ_BYTE, ctrl_codes[$urandom_range(0, 4)]);
            else if (sel < 70)
                send(ymr_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
            else if (sel < 82)
            begin
                n = $urandom_range(1, tmo_ticks + 2);
                repeat (n) send(ymr_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
            end
            else
            begin
                // truncated packet, recovered by timeout
                send(ymr_pkg::REQ_BYTE, $urandom_range(0, 1) ? ymr_pkg::HDR_STX
                                                              : ymr_pkg::HDR_SOH);
                n = $urandom_range(0, 24);
                repeat (n) send(ymr_pkg::REQ_BYTE, pick_data());
                while (cur_phase != ymr_pkg::PH_HEADER)
                    send(ymr_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
            end
        end
        while (cur_phase != ymr_pkg::PH_HEADER)
            send(ymr_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        rx_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_results.size() == 0)
                flag_mismatch($sformatf("unexpected result kind %0d value %02h", kind, value));
            else
            begin
                want = awaited_results.pop_front();
                if (kind !== want.kind)
                    flag_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
                if (value !== want.value)
                    flag_mismatch($sformatf("value %02h, want %02h", value, want.value));
                if (block_number !== want.blk)
                    flag_mismatch($sformatf("block_number %02h, want %02h",
                                            block_number, want.blk));
                if (byte_index !== want.idx)
                    flag_mismatch($sformatf("byte_index %0d, want %0d", byte_index, want.idx));
            end
        end
    end

    // output side pacing, with one long hold-off on request
    initial
    begin
        int hold;
        int run;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [15:0] plan [5];
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        req_type <= 1'b0;
        rx_byte <= 8'h00;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 16'h0000;
        cur_phase = ymr_pkg::PH_HEADER;
        hdr_code = '0;
        pkt_num = '0;
        pkt_compl = '0;
        data_cnt = '0;
        crc_run = '0;
        crc_hi = '0;
        idle_cnt = '0;
        tmo_ticks = ymr_pkg::TIMEOUT_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (i == SHORT_FROM)
                set_timeout(16'd4);
            for (int r = 1; r <= dir_rows[i].rep; r++)
                push_item(dir_rows[i].rq, dir_rows[i].b,
                          dir_rows[i].typed && r == dir_rows[i].rep, dir_rows[i].want);
        end

        // timeout sweep, including zero: every tick expires
        plan = '{16'd1, 16'd0, 16'd7, 16'($urandom_range(8, 20)), 16'd2};
        foreach (plan[p])
        begin
            set_timeout(plan[p]);
            steady = (p == 2);
            tick_pct = (plan[p] > 16'd3) ? 2 : 0;
            random_traffic((p == 3) ? 90 : 15);
        end

        // full packet with output held off, so the input backs up
        set_timeout(ymr_pkg::IDLE_MAX);
        steady = 1'b1;
        tick_pct = 0;
        long_hold_req = 1'b1;
        wait (long_hold_req == 1'b0);
        send_packet(ymr_pkg::HDR_SOH, 1'b1, 1'b1);

        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
